// ----- rtl/mmul_pkg.sv -----
// Shared constants and types for the matrix multiply block.
package mmul_pkg;

    localparam int MAX_DIM_DEF = 8;     // default largest matrix dimension
    localparam int DIM_W       = 4;     // width of a dimension register
    localparam int ROW_W       = 3;     // width of a row or column index field
    localparam int VAL_W       = 16;    // signed Q8.8 element
    localparam int MUL_W       = 2 * VAL_W;
    localparam int PROD_W      = 35;    // signed Q19.16 dot product
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // One element of an A row traveling down the cell chain.
    typedef struct packed {
        logic                    vld;
        logic                    first;
        logic [ROW_W-1:0]        k;
        logic signed [VAL_W-1:0] a;
    } t_tok;

    // Write of one B element, seen by every cell.
    typedef struct packed {
        logic                    en;
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_bwr;

    // Unload control for the result shift chain.
    typedef struct packed {
        logic load;
        logic shift;
    } t_ctl;

endpackage

// ----- rtl/matrix_multiply.sv -----
// Top level of the fixed-point matrix multiply block: configuration and cell chain.
//
// Computes C = A x B with signed Q8.8 elements and exact signed Q19.16 sums.
// A write request (mode 0 for A, mode 1 for B) never raises busy, so element
// loads can be issued back to back. A compute request (mode 2) raises busy
// and produces the rows_a*cols_b elements of C in row-major order, one per
// strobe cycle, with o_last on the final one; the receiver cannot stall, so
// capture o_out_row/o_out_col/o_product whenever o_strobe is high. Per row
// of a compute request, the sequencer reads inner_dim A elements from its
// A store one a cycle, the elements ripple down a chain of MAX_DIM column
// cells (each holding one column of B and its own accumulator), and the
// finished row then shifts out of the chain one element a cycle. Mode 3
// requests are dropped, as are writes with row or column at or beyond
// MAX_DIM. Dimension registers are written through the configuration
// channel, which is always ready; values of 0 act as 1 and values above
// MAX_DIM act as MAX_DIM. Write them only while busy is low. Reading an A or
// B element that was never written since reset gives an undefined result.
module matrix_multiply
    import mmul_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     start,
    output logic                     busy,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [ROW_W-1:0]         i_row,
    input  logic [ROW_W-1:0]         i_col,
    input  logic signed [VAL_W-1:0]  i_value,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DIM_W-1:0]         i_cfg_data,
    // result channel
    output logic                     o_strobe,
    output logic [ROW_W-1:0]         o_out_row,
    output logic [ROW_W-1:0]         o_out_col,
    output logic signed [PROD_W-1:0] o_product,
    output logic                     o_last
);

    logic [DIM_W-1:0]         r_rows_a;
    logic [DIM_W-1:0]         r_inner_dim;
    logic [DIM_W-1:0]         r_cols_b;
    logic [DIM_W-1:0]         w_cfg_clamped;
    logic                     w_cfg_wr;

    t_tok                     w_tok [MAX_DIM + 1];
    logic signed [PROD_W-1:0] w_sh  [MAX_DIM + 1];
    t_bwr                     w_bwr;
    t_ctl                     w_ctl;

    // Clamp a written dimension into 1..MAX_DIM.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_clamped = DIM_W'(1);
        end else if (i_cfg_data > DIM_W'(MAX_DIM)) begin
            w_cfg_clamped = DIM_W'(MAX_DIM);
        end else begin
            w_cfg_clamped = i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(MAX_DIM);
            r_inner_dim <= DIM_W'(MAX_DIM);
            r_cols_b    <= DIM_W'(MAX_DIM);
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= w_cfg_clamped;
                CFG_INNER_DIM: r_inner_dim <= w_cfg_clamped;
                CFG_COLS_B:    r_cols_b    <= w_cfg_clamped;
                default: ;     // drop writes beyond the register list
            endcase
        end
    end

    mmul_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_rows_a    (r_rows_a),
        .i_inner_dim (r_inner_dim),
        .i_cols_b    (r_cols_b),
        .o_busy      (busy),
        .o_tok       (w_tok[0]),
        .o_bwr       (w_bwr),
        .o_ctl       (w_ctl),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last),
        .o_strobe    (o_strobe)
    );

    // A elements travel right along the chain; results shift left toward
    // cell 0, which drives the product port. The far end shifts in zero.
    assign w_sh[MAX_DIM] = '0;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mmul_cell #(
            .MAX_DIM (MAX_DIM),
            .IDX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g + 1]),
            .i_bwr   (w_bwr),
            .i_ctl   (w_ctl),
            .i_sh    (w_sh[g + 1]),
            .o_sh    (w_sh[g])
        );
    end

    assign o_product = w_sh[0];

endmodule

// ----- rtl/mmul_cell.sv -----
// One column cell: holds a column of B, multiplies, accumulates, shifts results out.
module mmul_cell
    import mmul_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int IDX     = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tok                     i_tok,
    output t_tok                     o_tok,
    input  t_bwr                     i_bwr,
    input  t_ctl                     i_ctl,
    input  logic signed [PROD_W-1:0] i_sh,
    output logic signed [PROD_W-1:0] o_sh
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [VAL_W-1:0]  r_b [MAX_DIM];
    t_tok                     r_tok;
    logic signed [MUL_W-1:0]  r_prod;
    logic                     r_pv;
    logic                     r_pfirst;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_sh;
    logic signed [PROD_W-1:0] w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_bwr.en && i_bwr.col == ROW_W'(IDX)) begin
            r_b[i_bwr.row[IW-1:0]] <= i_bwr.value;
        end
    end

    // pass the token on and form this cell's partial product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
            r_pv      <= i_tok.vld;
        end
        r_tok.first <= i_tok.first;
        r_tok.k     <= i_tok.k;
        r_tok.a     <= i_tok.a;
        r_pfirst    <= i_tok.first;
        r_prod      <= i_tok.a * r_b[i_tok.k[IW-1:0]];
    end

    assign w_prod_ext = {{(PROD_W - MUL_W){r_prod[MUL_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc <= r_pfirst ? w_prod_ext : r_acc + w_prod_ext;
        end
        if (i_ctl.load) begin
            r_sh <= r_acc;
        end else if (i_ctl.shift) begin
            r_sh <= i_sh;
        end
    end

    assign o_tok = r_tok;
    assign o_sh  = r_sh;

endmodule

// ----- rtl/mmul_seq.sv -----
// Sequencer: request decode, A store, row feed and result unload control.
module mmul_seq
    import mmul_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [ROW_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [DIM_W-1:0]        i_rows_a,
    input  logic [DIM_W-1:0]        i_inner_dim,
    input  logic [DIM_W-1:0]        i_cols_b,
    output logic                    o_busy,
    output t_tok                    o_tok,
    output t_bwr                    o_bwr,
    output t_ctl                    o_ctl,
    output logic [ROW_W-1:0]        o_out_row,
    output logic [ROW_W-1:0]        o_out_col,
    output logic                    o_last,
    output logic                    o_strobe
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DIM + 2);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FEED  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [IW-1:0]           r_i, n_i;
    logic [IW-1:0]           r_j, n_j;
    logic [IW-1:0]           r_k, n_k;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd;
    logic                    r_rdv;
    logic [IW-1:0]           r_rdk;

    logic                    w_acc;
    logic                    w_in_range;
    logic                    w_wr_a;
    logic [AW-1:0]           w_wr_addr;
    logic [AW-1:0]           w_rd_addr;
    logic                    w_k_last;
    logic                    w_i_last;
    logic                    w_j_last;
    logic                    w_drain_done;

    assign w_acc      = i_start && !o_busy;
    assign w_in_range = ({1'b0, i_row} < (ROW_W + 1)'(MAX_DIM))
                     && ({1'b0, i_col} < (ROW_W + 1)'(MAX_DIM));
    assign w_wr_a     = w_acc && w_in_range && i_mode == MODE_WR_A;
    assign w_wr_addr  = AW'(AW'(i_row[IW-1:0]) * AW'(MAX_DIM) + AW'(i_col[IW-1:0]));
    assign w_rd_addr  = AW'(AW'(r_i) * AW'(MAX_DIM) + AW'(r_k));

    assign w_k_last     = DIM_W'(r_k) == i_inner_dim - DIM_W'(1);
    assign w_i_last     = DIM_W'(r_i) == i_rows_a - DIM_W'(1);
    assign w_j_last     = DIM_W'(r_j) == i_cols_b - DIM_W'(1);
    assign w_drain_done = r_cnt == CW'(MAX_DIM + 1);

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem[w_wr_addr] <= i_value;
        end
        r_rd  <= r_mem[w_rd_addr];
        r_rdk <= r_k;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_mode == MODE_RUN) begin
                    n_state = S_FEED;
                    n_i     = '0;
                    n_k     = '0;
                end
            end
            S_FEED: begin
                n_k = r_k + IW'(1);
                if (w_k_last) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + CW'(1);
                if (w_drain_done) begin
                    n_state = S_EMIT;
                    n_j     = '0;
                end
            end
            S_EMIT: begin
                n_j = r_j + IW'(1);
                if (w_j_last) begin
                    if (w_i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FEED;
                        n_i     = r_i + IW'(1);
                        n_k     = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= r_state == S_FEED;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_cnt <= n_cnt;
    end

    assign o_busy    = r_state != S_IDLE;
    assign o_tok.vld   = r_rdv;
    assign o_tok.first = r_rdk == '0;
    assign o_tok.k     = ROW_W'(r_rdk);
    assign o_tok.a     = r_rd;

    assign o_bwr.en    = w_acc && w_in_range && i_mode == MODE_WR_B;
    assign o_bwr.row   = i_row;
    assign o_bwr.col   = i_col;
    assign o_bwr.value = i_value;

    assign o_ctl.load  = r_state == S_DRAIN && w_drain_done;
    assign o_ctl.shift = r_state == S_EMIT;

    assign o_strobe  = r_state == S_EMIT;
    assign o_out_row = ROW_W'(r_i);
    assign o_out_col = ROW_W'(r_j);
    assign o_last    = o_strobe && w_i_last && w_j_last;

    a_load_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_state == S_EMIT && r_j == '0)
        else $error("result load not followed by unload");

    a_run_starts_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_mode == MODE_RUN |=> r_state == S_FEED && r_i == '0 && r_k == '0)
        else $error("compute request did not start a row feed");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> r_state == S_IDLE)
        else $error("block still busy after final result");

    a_strobe_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !w_acc)
        else $error("request accepted while emitting results");

endmodule
